[rtl/b64d_pkg.sv]
package b64d_pkg;

  // Number of group requests that the queue between front and back can hold.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PAD   = 8'h3D;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // Index of a byte within a decoded group.
  localparam logic [1:0] BYTE_IDX0 = 2'd0;
  localparam logic [1:0] BYTE_IDX1 = 2'd1;
  localparam logic [1:0] BYTE_IDX2 = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_BAD
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [5:0] val;
  } char_class_t;

  // One request from the front to the back: a finished group or an error.
  typedef struct packed {
    logic [23:0] data;
    logic        emit1;
    logic        emit2;
    logic        last;
    logic        error;
  } group_req_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c.kind = KIND_BAD;
    c.val  = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      c.kind = KIND_DATA;
      c.val  = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      c.kind = KIND_DATA;
      c.val  = 6'(ch - 8'h61) + SEXTET_LOWER;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      c.kind = KIND_DATA;
      c.val  = 6'(ch - 8'h30) + SEXTET_DIGIT;
    end else if (ch == CH_PLUS) begin
      c.kind = KIND_DATA;
      c.val  = SEXTET_PLUS;
    end else if (ch == CH_SLASH) begin
      c.kind = KIND_DATA;
      c.val  = SEXTET_SLASH;
    end else if (ch == CH_PAD) begin
      c.kind = KIND_PAD;
    end
    return c;
  endfunction

endpackage

[rtl/base64_stream_decoder.sv]
// Streaming base64 decoder (standard alphabet, '=' padding). It takes one
// character per cycle while the queue has room and returns decoded bytes
// one per cycle while the receiver is ready. The front classifies each
// character and gathers groups of four; every finished group, or every
// error, becomes one request in a two-entry queue. The back drains a request
// as one, two or three bytes on the output, skipping the bytes that padding
// removes. Sustained input rate is one character per cycle: a group of four
// characters gives at most three bytes, so the back keeps up and the queue
// absorbs short output stalls. Malformed input (a bad character, a pad in
// the first or second place of a group, or a string that ends inside a
// group) gives one result with error and last set and byte zero; the rest
// of the string, up to the character marked last, is then dropped without
// results. Pads in mid-stream are accepted.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);

  logic       push_valid;
  group_req_t push_req;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  group_req_t q_req;

  // A character is taken whenever the queue has room for the request that
  // it might produce.
  assign in_ready = !q_full;

  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_req   (push_req)
  );

  b64d_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push_valid),
    .wr_req (push_req),
    .rd_en  (q_pop),
    .rd_req (q_req),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

[rtl/b64d_front.sv]
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       push_valid,
  output group_req_t push_req
);

  logic [23:0] accum_r, accum_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        bad_r, bad_nxt;
  logic        discard_r, discard_nxt;

  char_class_t cls;
  logic        accept;
  logic [23:0] accum_sh;
  logic        bad_now;
  logic        third_now;
  logic        fourth_now;

  assign accept = in_valid && in_ready;

  always_comb begin
    cls        = classify(in_char);
    accum_sh   = {accum_r[17:0], cls.val};
    bad_now    = bad_r || (cls.kind == KIND_BAD) ||
                 ((cls.kind == KIND_PAD) && (pos_r < 2'd2));
    third_now  = third_pad_r || ((cls.kind == KIND_PAD) && (pos_r == 2'd2));
    fourth_now = (cls.kind == KIND_PAD) && (pos_r == 2'd3);

    accum_nxt     = accum_r;
    pos_nxt       = pos_r;
    third_pad_nxt = third_pad_r;
    bad_nxt       = bad_r;
    discard_nxt   = discard_r;
    push_valid    = 1'b0;
    push_req.data  = accum_sh;
    push_req.emit1 = !third_now;
    push_req.emit2 = !fourth_now;
    push_req.last  = in_last;
    push_req.error = 1'b0;

    if (accept) begin
      if (discard_r) begin
        if (in_last) begin
          discard_nxt   = 1'b0;
          accum_nxt     = '0;
          pos_nxt       = '0;
          third_pad_nxt = 1'b0;
          bad_nxt       = 1'b0;
        end
      end else if (pos_r != 2'd3) begin
        if (in_last) begin
          // The string ends inside a group.
          push_valid     = 1'b1;
          push_req.error = 1'b1;
          push_req.last  = 1'b1;
          accum_nxt      = '0;
          pos_nxt        = '0;
          third_pad_nxt  = 1'b0;
          bad_nxt        = 1'b0;
        end else begin
          accum_nxt     = accum_sh;
          pos_nxt       = pos_r + 2'd1;
          third_pad_nxt = third_now;
          bad_nxt       = bad_now;
        end
      end else begin
        push_valid = 1'b1;
        if (bad_now) begin
          push_req.error = 1'b1;
          push_req.last  = 1'b1;
          discard_nxt    = !in_last;
        end
        accum_nxt     = '0;
        pos_nxt       = '0;
        third_pad_nxt = 1'b0;
        bad_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      pos_r       <= '0;
      third_pad_r <= 1'b0;
      bad_r       <= 1'b0;
      discard_r   <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      pos_r       <= pos_nxt;
      third_pad_r <= third_pad_nxt;
      bad_r       <= bad_nxt;
      discard_r   <= discard_nxt;
    end
  end

endmodule

[rtl/b64d_fifo.sv]
module b64d_fifo
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  group_req_t wr_req,
  input  logic       rd_en,
  output group_req_t rd_req,
  output logic       full,
  output logic       empty
);

  group_req_t            store_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_req = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_req;
    end
  end

endmodule

[rtl/b64d_back.sv]
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  group_req_t q_req,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);

  group_req_t cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       final_byte;
  logic       take;

  assign out_valid = busy_r;
  assign take      = busy_r && out_ready;

  always_comb begin
    case (idx_r)
      BYTE_IDX0: final_byte = !cur_r.emit1 && !cur_r.emit2;
      BYTE_IDX1: final_byte = !cur_r.emit2;
      default:   final_byte = 1'b1;
    endcase
    final_byte = final_byte || cur_r.error;

    out_byte = 8'd0;
    if (!cur_r.error) begin
      case (idx_r)
        BYTE_IDX0: out_byte = cur_r.data[23:16];
        BYTE_IDX1: out_byte = cur_r.data[15:8];
        default:   out_byte = cur_r.data[7:0];
      endcase
    end
    out_last  = cur_r.last && final_byte;
    out_error = cur_r.error;

    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    q_pop    = 1'b0;

    if (!busy_r || (take && final_byte)) begin
      // Load the next group as soon as the current one has drained.
      q_pop    = !q_empty;
      busy_nxt = !q_empty;
      cur_nxt  = q_req;
      idx_nxt  = BYTE_IDX0;
    end else if (take) begin
      idx_nxt = (idx_r == BYTE_IDX0 && cur_r.emit1) ? BYTE_IDX1 : BYTE_IDX2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= BYTE_IDX0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One decoded byte as it should appear on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } decoded_t;

  // The kinds of damage that a random string may carry.
  typedef enum {
    FLAW_NONE,
    FLAW_BAD_CHAR,
    FLAW_SHORT,
    FLAW_MID_PAD,
    FLAW_NOISE
  } flaw_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_char   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  base64_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes that the decoder owes us, oldest first.
  decoded_t expected_bytes[$];
  int       fail_count = 0;
  int       chars_sent = 0;

  // Idling controls. The sender's gaps are only used by the sending task, so a
  // blocking write is safe; the receiver's stalls are read by a clocked process
  // and are therefore changed with nonblocking writes only.
  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;

  // Our own copy of the decoder's group state. All of it is zero after reset.
  logic [23:0] group_bits    = '0;
  logic [1:0]  group_fill    = '0;
  logic        pad_third     = 1'b0;
  logic        pad_fourth    = 1'b0;
  logic        group_broken  = 1'b0;
  logic        dropping      = 1'b0;

  // Maps a character onto the standard alphabet. Pads and rejected characters
  // give a sextet of zero, which still shifts into the group.
  function automatic char_kind_t classify_char(input logic [7:0] ch,
                                               output logic [5:0] sextet);
    sextet = 6'd0;
    if (ch >= "A" && ch <= "Z") begin
      sextet = 6'(ch - "A");
      return KIND_DATA;
    end
    if (ch >= "a" && ch <= "z") begin
      sextet = 6'(ch - "a") + SEXTET_LOWER;
      return KIND_DATA;
    end
    if (ch >= "0" && ch <= "9") begin
      sextet = 6'(ch - "0") + SEXTET_DIGIT;
      return KIND_DATA;
    end
    if (ch == CH_PLUS) begin
      sextet = SEXTET_PLUS;
      return KIND_DATA;
    end
    if (ch == CH_SLASH) begin
      sextet = SEXTET_SLASH;
      return KIND_DATA;
    end
    if (ch == CH_PAD) begin
      return KIND_PAD;
    end
    return KIND_BAD;
  endfunction

  // The opposite mapping, used to build well-formed random text.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    if (v < SEXTET_LOWER) begin
      return 8'("A") + 8'(v);
    end
    if (v < SEXTET_DIGIT) begin
      return 8'("a") + 8'(v - SEXTET_LOWER);
    end
    if (v < SEXTET_PLUS) begin
      return 8'("0") + 8'(v - SEXTET_DIGIT);
    end
    return (v == SEXTET_PLUS) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic void owe_byte(input logic [7:0] data, input logic last,
                                   input logic error);
    decoded_t d;
    d.data  = data;
    d.last  = last;
    d.error = error;
    expected_bytes.push_back(d);
  endfunction

  function automatic void clear_group();
    group_bits   = '0;
    group_fill   = '0;
    pad_third    = 1'b0;
    pad_fourth   = 1'b0;
    group_broken = 1'b0;
  endfunction

  // Works out what one accepted character makes the decoder produce and
  // queues those bytes.
  function automatic void decode_char(input logic [7:0] ch, input logic lst);
    logic [5:0] sextet;
    char_kind_t kind;
    // Once an error has been reported, the rest of the string is swallowed
    // silently; the character marked last just re-arms the decoder.
    if (dropping) begin
      if (lst) begin
        dropping = 1'b0;
        clear_group();
      end
      return;
    end
    kind = classify_char(ch, sextet);
    if (kind == KIND_BAD) begin
      group_broken = 1'b1;
    end
    // A pad in the first or second place spoils the group; in the third or
    // fourth place it just suppresses a byte.
    if (kind == KIND_PAD) begin
      if (group_fill < 2'd2) begin
        group_broken = 1'b1;
      end else if (group_fill == 2'd2) begin
        pad_third = 1'b1;
      end else begin
        pad_fourth = 1'b1;
      end
    end
    group_bits = {group_bits[17:0], sextet};
    if (group_fill != 2'd3) begin
      group_fill = group_fill + 2'd1;
      // The string ends in the middle of a group.
      if (lst) begin
        owe_byte(8'h00, 1'b1, 1'b1);
        clear_group();
      end
      return;
    end
    if (group_broken) begin
      owe_byte(8'h00, 1'b1, 1'b1);
      clear_group();
      dropping = !lst;
      return;
    end
    // The last flag goes on whichever byte of the group comes out last.
    owe_byte(group_bits[23:16], lst && pad_third && pad_fourth, 1'b0);
    if (!pad_third) begin
      owe_byte(group_bits[15:8], lst && pad_fourth, 1'b0);
    end
    if (!pad_fourth) begin
      owe_byte(group_bits[7:0], lst, 1'b0);
    end
    clear_group();
  endfunction

  // Offers one character as a request on the input channel and holds it until
  // the decoder takes it. Called, and returning, just after a rising edge.
  task automatic send_char(input logic [7:0] ch, input logic lst);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    in_last  <= lst;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    decode_char(ch, lst);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic ends);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], ends && (i == s.len() - 1));
    end
  endtask

  // Whole groups of ordinary characters from both ends of the alphabet,
  // first inside a string and then closing it.
  task automatic test_full_groups();
    send_text("AZaz", 1'b0);
    send_text("09+/", 1'b1);
  endtask

  // Padding at the close of a string, pads in mid-stream, and a pad in the
  // second place, which spoils its group and gives an error result.
  task automatic test_padding();
    send_text("QQ==", 1'b1);
    send_text("QUE=", 1'b0);
    send_text("A=B/", 1'b1);
  endtask

  // A pad in the second place and a character outside the alphabet spoil a
  // group; the error comes when the group completes and the rest of the
  // string, down to the character marked last, is dropped. Then strings
  // that end inside a group, one of them starting with a pad.
  task automatic test_errors();
    send_text("A=", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("B", 1'b0);
    send_char(8'h00, 1'b1);
    send_text("=A", 1'b1);
    send_text("AB", 1'b1);
  endtask

  // A random string: mostly valid text with random content and random closing
  // padding, sometimes damaged, sometimes plain noise.
  task automatic send_random_string();
    logic [7:0] text[$];
    int         n_groups;
    int         pick;
    int         i;
    flaw_t      flaw;
    n_groups = $urandom_range(1, 4);
    for (i = 0; i < n_groups * 4; i++) begin
      text.push_back(sextet_to_char(6'($urandom_range(0, 63))));
    end
    pick = $urandom_range(0, 2);
    if (pick >= 1) begin
      text[text.size() - 1] = CH_PAD;
    end
    if (pick == 2) begin
      text[text.size() - 2] = CH_PAD;
    end
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      flaw = FLAW_NONE;
    end else if (pick == 6) begin
      flaw = FLAW_BAD_CHAR;
    end else if (pick == 7) begin
      flaw = FLAW_SHORT;
    end else if (pick == 8) begin
      flaw = FLAW_MID_PAD;
    end else begin
      flaw = FLAW_NOISE;
    end
    case (flaw)
      FLAW_BAD_CHAR: begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      FLAW_SHORT: begin
        repeat ($urandom_range(1, 3)) void'(text.pop_back());
      end
      FLAW_MID_PAD: begin
        text[4 * $urandom_range(0, n_groups - 1) + $urandom_range(1, 3)] = CH_PAD;
      end
      FLAW_NOISE: begin
        text.delete();
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
    for (i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  // Random strings with idling switched on and off from one string to the
  // next, so that gaps and stalls land on every phase of a group.
  task automatic test_random_with_idling(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on <= ($urandom_range(0, 3) != 0);
      send_random_string();
    end
  endtask

  // Random strings at full rate on both sides.
  task automatic test_random_full_rate(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    while (chars_sent < stop_at) begin
      send_random_string();
    end
  endtask

  // The receiver stalls in bursts, which start at random while stalls are
  // enabled; a burst runs to its end, and otherwise the receiver is ready.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every byte that the decoder hands over is compared with the oldest byte
  // still owed. Values are taken as they stood just before the edge.
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h out_last %0b out_error %0b",
               out_byte, out_last, out_error);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
        if (out_error !== want.error) begin
          $error("out_error: expected %0b, got %0b", want.error, out_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // Reset is held at the start and then released for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_groups();
    test_padding();
    test_errors();
    test_random_with_idling(360);
    test_random_full_rate(100);

    // Everything has been sent; wait for the last bytes, then go on idling so
    // that anything stray would still be caught.
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // A hung handshake or missing bytes end the run here.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
